>>> hw/rtl/rgbif_pkg.sv
package rgbif_pkg;

  // Storage geometry.
  localparam int PIXEL_COUNT     = 4096;
  localparam int INTEGRATOR_BITS = 24;
  localparam int ADDR_BITS       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int SUM_BITS        = INTEGRATOR_BITS + 1;
  localparam int WORD_BITS       = 3 * INTEGRATOR_BITS;

  // Field widths of the item payloads.
  localparam int INDEX_BITS     = 12;
  localparam int CHANNEL_BITS   = 8;
  localparam int THRESHOLD_BITS = 16;
  localparam int IN_DATA_BITS   = 40;
  localparam int OUT_DATA_BITS  = 8;

  // Result queue between the update stage and the output side.
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

  localparam logic [INTEGRATOR_BITS-1:0] FULL_SCALE = {INTEGRATOR_BITS{1'b1}};
  localparam logic [THRESHOLD_BITS-1:0]  THRESHOLD_RESET = 16'd255;

  typedef enum logic {
    ACT_ACCUMULATE = 1'b0,
    ACT_QUERY      = 1'b1
  } action_t;

  typedef enum logic {
    REG_FIRE_THRESHOLD = 1'b0,
    REG_KEEP_RESIDUAL  = 1'b1
  } reg_index_t;

endpackage

>>> hw/rtl/rgb_integrate_and_fire_spikes_top.sv
// Per-pixel integrate-and-fire spike encoder for RGB pixels. Each pixel owns three
// saturating integrators held in one on-chip memory word. An accumulate item (tuser 0) adds
// the pixel's red, green and blue values; a query item (tuser 1) returns one item whose three
// bits flag the channels whose integrator exceeds fire_threshold, and those integrators are
// then reduced by the threshold or cleared as keep_residual selects. The block takes one item
// per clock while the result queue has room: the single read-modify-write pass through the
// integrator memory (read in the accept cycle, update and write back in the next) sets that
// rate, and a forwarding register covers back-to-back items on the same pixel. A query result
// passes through the update stage into a four-entry queue and is offered on the output from
// there, so a stalled output side does not stop input until that queue fills. After reset the
// memory is cleared one entry per cycle; s_tready stays low until the pass ends.
// Configuration writes are taken at any time but must only be made while the block is idle.
module rgb_integrate_and_fire_spikes_top (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pixel_index[11:0], red_value[19:12], green_value[27:20],
                                 // blue_value[35:28], zero[39:36]
  input  logic [0:0]  s_tuser,   // action[0]
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // spike_red[0], spike_green[1], spike_blue[2], zero[7:3]
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IB = rgbif_pkg::INTEGRATOR_BITS;
  localparam int AB = rgbif_pkg::ADDR_BITS;
  localparam int CB = rgbif_pkg::CHANNEL_BITS;

  // Configuration registers.
  logic [rgbif_pkg::THRESHOLD_BITS-1:0] fire_threshold;
  logic                                 keep_residual;

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_threshold <= rgbif_pkg::THRESHOLD_RESET;
      keep_residual  <= 1'b1;
    end else if (cfg_we) begin
      unique case (rgbif_pkg::reg_index_t'(cfg_index))
        rgbif_pkg::REG_FIRE_THRESHOLD: fire_threshold <= cfg_data;
        rgbif_pkg::REG_KEEP_RESIDUAL:  keep_residual  <= cfg_data[0];
        default:                       fire_threshold <= fire_threshold;
      endcase
    end
  end

  // Input field unpacking.
  logic [rgbif_pkg::INDEX_BITS-1:0] in_pixel;
  logic [CB-1:0]                    in_red;
  logic [CB-1:0]                    in_green;
  logic [CB-1:0]                    in_blue;
  logic                             in_accept;
  logic                             in_range;
  logic [AB-1:0]                    in_addr;

  assign in_pixel  = s_tdata[11:0];
  assign in_red    = s_tdata[19:12];
  assign in_green  = s_tdata[27:20];
  assign in_blue   = s_tdata[35:28];
  assign in_accept = s_tvalid && s_tready;
  assign in_range  = 32'(in_pixel) < 32'(rgbif_pkg::PIXEL_COUNT);
  assign in_addr   = AB'(in_pixel);

  // Clearing pass after reset.
  logic          clr_active;
  logic [AB-1:0] clr_addr;
  logic          clr_last;

  assign clr_last = clr_addr == AB'(rgbif_pkg::PIXEL_COUNT - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_active <= !clr_last;
      clr_addr   <= clr_addr + AB'(1);
    end
  end

  // Update stage: the item whose memory word is being read.
  logic                  s1_valid;
  rgbif_pkg::action_t    s1_action;
  logic                  s1_in_range;
  logic [AB-1:0]         s1_addr;
  logic [CB-1:0]         s1_red;
  logic [CB-1:0]         s1_green;
  logic [CB-1:0]         s1_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action   <= rgbif_pkg::action_t'(s_tuser[0]);
      s1_in_range <= in_range;
      s1_addr     <= in_addr;
      s1_red      <= in_red;
      s1_green    <= in_green;
      s1_blue     <= in_blue;
    end
  end

  // Integrator memory: one word per pixel, red in the low bits.
  logic [rgbif_pkg::WORD_BITS-1:0] mem [rgbif_pkg::PIXEL_COUNT];
  logic [rgbif_pkg::WORD_BITS-1:0] mem_rdata;
  logic                            mem_we;
  logic [AB-1:0]                   mem_waddr;
  logic [rgbif_pkg::WORD_BITS-1:0] mem_wdata;
  logic                            s1_we;
  logic [rgbif_pkg::WORD_BITS-1:0] s1_wdata;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_rdata <= mem[in_addr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // The clearing pass and the update stage never write in the same cycle.
  always_comb begin
    mem_we    = clr_active || s1_we;
    mem_waddr = clr_active ? clr_addr : s1_addr;
    mem_wdata = clr_active ? '0 : s1_wdata;
  end

  // Forwarding of the last write, which the read of the next item cannot see yet.
  logic                            fwd_valid;
  logic [AB-1:0]                   fwd_addr;
  logic [rgbif_pkg::WORD_BITS-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_we;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= s1_wdata;
    end
  end

  // Channel arithmetic.
  function automatic logic [IB-1:0] integrate(input logic [IB-1:0] cur,
                                              input logic [CB-1:0] add);
    logic [rgbif_pkg::SUM_BITS-1:0] sum;
    sum = {1'b0, cur} + rgbif_pkg::SUM_BITS'(add);
    return sum[IB] ? rgbif_pkg::FULL_SCALE : sum[IB-1:0];
  endfunction

  function automatic logic [IB-1:0] discharge(input logic [IB-1:0] cur,
                                              input logic [IB-1:0] thr,
                                              input logic          keep);
    return keep ? cur - thr : '0;
  endfunction

  logic [rgbif_pkg::WORD_BITS-1:0] cur_word;
  logic [IB-1:0]                   cur_r;
  logic [IB-1:0]                   cur_g;
  logic [IB-1:0]                   cur_b;
  logic [IB-1:0]                   thr_ext;
  logic                            fire_r;
  logic                            fire_g;
  logic                            fire_b;
  logic                            s1_query;
  logic [IB-1:0]                   new_r;
  logic [IB-1:0]                   new_g;
  logic [IB-1:0]                   new_b;

  // Read-modify-write of the pixel's three integrators.
  always_comb begin
    cur_word = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : mem_rdata;
    cur_r    = cur_word[IB-1:0];
    cur_g    = cur_word[2*IB-1:IB];
    cur_b    = cur_word[3*IB-1:2*IB];
    thr_ext  = IB'(fire_threshold);
    s1_query = s1_valid && s1_action == rgbif_pkg::ACT_QUERY;
    fire_r   = s1_in_range && cur_r > thr_ext;
    fire_g   = s1_in_range && cur_g > thr_ext;
    fire_b   = s1_in_range && cur_b > thr_ext;
    if (s1_action == rgbif_pkg::ACT_QUERY) begin
      new_r = fire_r ? discharge(cur_r, thr_ext, keep_residual) : cur_r;
      new_g = fire_g ? discharge(cur_g, thr_ext, keep_residual) : cur_g;
      new_b = fire_b ? discharge(cur_b, thr_ext, keep_residual) : cur_b;
    end else begin
      new_r = integrate(cur_r, s1_red);
      new_g = integrate(cur_g, s1_green);
      new_b = integrate(cur_b, s1_blue);
    end
    s1_we    = s1_valid && s1_in_range;
    s1_wdata = {new_b, new_g, new_r};
  end

  // Result queue.
  logic [2:0]                  out_q [rgbif_pkg::OUT_DEPTH];
  logic [rgbif_pkg::OUT_PTR_BITS-1:0] out_wr_ptr;
  logic [rgbif_pkg::OUT_PTR_BITS-1:0] out_rd_ptr;
  logic [rgbif_pkg::OUT_PTR_BITS:0]   out_count;
  logic                               out_pop;
  logic [rgbif_pkg::OUT_PTR_BITS:0]   out_need;

  assign out_pop  = m_tvalid && m_tready;
  assign out_need = out_count + (rgbif_pkg::OUT_PTR_BITS + 1)'(s1_query);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (s1_query) begin
        out_wr_ptr <= out_wr_ptr + rgbif_pkg::OUT_PTR_BITS'(1);
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + rgbif_pkg::OUT_PTR_BITS'(1);
      end
      out_count <= out_count + (rgbif_pkg::OUT_PTR_BITS + 1)'(s1_query)
                 - (rgbif_pkg::OUT_PTR_BITS + 1)'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_query) begin
      out_q[out_wr_ptr] <= {fire_b, fire_g, fire_r};
    end
  end

  // An item is taken only when its possible result is sure of a queue slot.
  assign s_tready = !clr_active
                 && out_need <= (rgbif_pkg::OUT_PTR_BITS + 1)'(rgbif_pkg::OUT_DEPTH - 1);
  assign m_tvalid = out_count != '0;
  assign m_tdata  = {5'b0, out_q[out_rd_ptr]};

  // Checks.
  a_clear_ends_at_last: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_active) |-> $past(clr_addr) == AB'(rgbif_pkg::PIXEL_COUNT - 1))
    else $error("clearing pass ended before the last entry");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_query |-> out_count < (rgbif_pkg::OUT_PTR_BITS + 1)'(rgbif_pkg::OUT_DEPTH))
    else $error("query result with a full result queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= (rgbif_pkg::OUT_PTR_BITS + 1)'(rgbif_pkg::OUT_DEPTH))
    else $error("result queue count out of range");

  a_forward_tracks_write: assert property (@(posedge clk) disable iff (rst)
    s1_we |=> fwd_valid && fwd_addr == $past(s1_addr) && fwd_data == $past(s1_wdata))
    else $error("forwarding register lost the last write");

  a_no_clash: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s1_valid && !in_accept)
    else $error("item in flight during clearing pass");

endmodule
